FILE: hw/rtl/hhve_pkg.sv
// ----------------------------------------------------------------------------
// hhve_pkg: HTTP header value extractor types and helpers
// Payload structs, parse phases, result kinds and the per-byte line logic.
// ----------------------------------------------------------------------------
`default_nettype none

package hhve_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [1:0] KIND_BYTE       = 2'd0;
  localparam logic [1:0] KIND_FOUND      = 2'd1;
  localparam logic [1:0] KIND_INCOMPLETE = 2'd2;
  localparam logic [1:0] KIND_ABSENT     = 2'd3;

  localparam logic CFG_IDX_NAME = 1'b0;
  localparam logic CFG_IDX_LEN  = 1'b1;

  localparam logic [63:0] NAME_RESET     = 64'd251061825352; // "Host:"
  localparam logic [3:0]  NAME_LEN_RESET = 4'd5;

  typedef enum logic [2:0] {
    PH_REQ    = 3'd0,
    PH_NAME   = 3'd1,
    PH_AFTER  = 3'd2,
    PH_BLANKS = 3'd3,
    PH_VALUE  = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [9:0] out_value_len;
    logic       out_last;
  } out_item_t;

  // Line parser state
  typedef struct packed {
    phase_t     phase;
    logic [3:0] pos;
    logic       matching;
    logic [3:0] cnt;
    logic [9:0] vcnt;
  } parse_st_t;

  typedef struct packed {
    parse_st_t  st;
    logic       emit;
    logic [7:0] val;
  } step_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // One content byte of a line (anything but a CR LF terminator)
  function automatic step_t content_step(input parse_st_t st, input logic [7:0] c,
                                         input logic [63:0] name, input logic [3:0] nlen,
                                         input logic [9:0] cap);
    step_t      r;
    logic       blank;
    logic [7:0] nb;
    logic [3:0] pos_inc;
    r       = '{st: st, emit: 1'b0, val: c};
    blank   = (c == CH_SPACE) || (c == CH_TAB);
    nb      = 8'(name >> {st.pos[2:0], 3'b000});
    pos_inc = st.pos + 4'd1;
    if (st.phase != PH_REQ && st.phase != PH_DONE && st.cnt < 4'd15) begin
      r.st.cnt = st.cnt + 4'd1;
    end
    case (st.phase)
      PH_NAME: begin
        if (st.matching) begin
          if (fold(c) != fold(nb)) begin
            r.st.matching = 1'b0;
          end else begin
            r.st.pos = pos_inc;
            if (pos_inc >= nlen) r.st.phase = PH_AFTER;
          end
        end
      end
      PH_AFTER, PH_BLANKS: begin
        if (blank) begin
          r.st.phase = PH_BLANKS;
        end else begin
          r.st.phase = PH_VALUE;
          r.emit     = 1'b1;
        end
      end
      PH_VALUE: begin
        r.emit = 1'b1;
      end
      default: ;
    endcase
    if (r.emit && st.vcnt < cap) r.st.vcnt = st.vcnt + 10'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/http_header_value_extractor.sv
// ----------------------------------------------------------------------------
// http_header_value_extractor: HTTP header value extraction
// Streams request bytes, finds the configured header and emits its value.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------
//  in_     | input     | in_valid/in_stall  | in_item_t  (byte, last)
//  out_    | output    | out_valid/out_stall| out_item_t (kind, byte, length, last)
//  cfg_    | input     | cfg_valid/cfg_ready| index (1 bit), 64-bit data
//
//  One request byte per cycle while in_stall is low. Each byte is parsed in
//  the cycle it is taken and its results (none, one or two) are written into
//  a four-entry result queue, which drives out_data directly.
//  in_stall is raised while fewer than two queue slots are free, so a byte
//  that releases two value bytes stalls the input only when the output lags.
//  Reset (rst_n low, synchronous) empties the queue, returns the parser to
//  the request line and reloads the header name to "Host:" (length 5).
//  cfg_ready is always high; a register write takes effect on the next byte.
//
`default_nettype none

module http_header_value_extractor
  import hhve_pkg::*;
#(
  parameter int MAX_VALUE_LEN  = 1023,
  parameter int MAX_NAME_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request bytes
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire in_item_t    in_data,
  // results
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      out_item_t   out_data,
  // configuration writes
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  localparam logic [9:0] VALUE_CAP = 10'((MAX_VALUE_LEN > 1023) ? 1023 : MAX_VALUE_LEN);
  localparam logic [3:0] NAME_MAX  = 4'(MAX_NAME_BYTES);
  localparam int         QDEPTH    = 4;

  // configuration
  logic [63:0] name_r;
  logic [3:0]  name_len_r;
  logic [3:0]  nlen;

  // parser
  parse_st_t st_r, st_nxt;
  logic      prev_cr_r, prev_cr_nxt;
  parse_st_t st_line, st_idle;
  step_t     s1, s2;
  logic [7:0] first_ch;

  // results of the current byte
  out_item_t res_a, res_b;
  logic [1:0] push_n;
  logic       status;

  // result queue
  out_item_t  q_mem [QDEPTH];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] q_cnt_r;
  logic       in_fire, out_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign in_stall  = (q_cnt_r > 3'(QDEPTH - 2));
  assign out_valid = (q_cnt_r != 3'd0);
  assign out_data  = q_mem[rd_ptr_r];

  assign nlen = (name_len_r > NAME_MAX) ? NAME_MAX : name_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_r     <= NAME_RESET;
      name_len_r <= NAME_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_NAME: name_r     <= cfg_wdata;
        CFG_IDX_LEN:  name_len_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // start of a header line, and start of a request
  always_comb begin
    st_line = '{phase: (nlen == 4'd0) ? PH_AFTER : PH_NAME,
                pos: 4'd0, matching: 1'b1, cnt: 4'd0, vcnt: 10'd0};
    st_idle = '{phase: PH_REQ, pos: 4'd0, matching: 1'b1, cnt: 4'd0, vcnt: 10'd0};
  end

  // A held CR that is not followed by LF is a line byte in its own right,
  // so up to two content steps run back to back.
  assign first_ch = prev_cr_r ? CH_CR : in_data.in_byte;
  assign s1 = content_step(st_r, first_ch, name_r, nlen, VALUE_CAP);
  assign s2 = content_step(s1.st, in_data.in_byte, name_r, nlen, VALUE_CAP);

  always_comb begin
    st_nxt      = st_r;
    prev_cr_nxt = prev_cr_r;
    res_a       = '{out_kind: KIND_BYTE, out_byte: s1.val, out_value_len: 10'd0,
                    out_last: 1'b0};
    res_b       = '{out_kind: KIND_BYTE, out_byte: s2.val, out_value_len: 10'd0,
                    out_last: 1'b0};
    push_n      = 2'd0;
    status      = 1'b0;
    if (in_fire) begin
      if (st_r.phase == PH_DONE) begin
        // drain the rest of the request silently
        if (in_data.in_last) begin
          st_nxt      = st_idle;
          prev_cr_nxt = 1'b0;
        end
      end else begin
        if (prev_cr_r && in_data.in_byte == CH_LF) begin
          // end of line
          prev_cr_nxt = 1'b0;
          case (st_r.phase)
            PH_REQ: st_nxt = st_line;
            PH_NAME, PH_AFTER: begin
              if (st_r.cnt == 4'd0) begin
                res_a  = '{out_kind: KIND_ABSENT, out_byte: 8'd0,
                           out_value_len: 10'd0, out_last: 1'b1};
                push_n = 2'd1;
                status = 1'b1;
                st_nxt.phase = PH_DONE;
              end else begin
                st_nxt = st_line;
              end
            end
            PH_BLANKS, PH_VALUE: begin
              res_a  = '{out_kind: KIND_FOUND, out_byte: 8'd0,
                         out_value_len: st_r.vcnt, out_last: 1'b1};
              push_n = 2'd1;
              status = 1'b1;
              st_nxt.phase = PH_DONE;
            end
            default: ;
          endcase
        end else if (in_data.in_byte == CH_CR) begin
          // hold this CR; a held one before it becomes a line byte
          prev_cr_nxt = 1'b1;
          if (prev_cr_r) begin
            st_nxt = s1.st;
            push_n = {1'b0, s1.emit};
          end
        end else if (prev_cr_r) begin
          prev_cr_nxt = 1'b0;
          st_nxt      = s2.st;
          if (s1.emit) begin
            push_n = s2.emit ? 2'd2 : 2'd1;
          end else if (s2.emit) begin
            res_a  = res_b;
            push_n = 2'd1;
          end
        end else begin
          st_nxt = s1.st;
          push_n = {1'b0, s1.emit};
        end

        // buffer end: unless a status was just pushed, incomplete replaces any value bytes of this byte
        if (in_data.in_last) begin
          if (!status) begin
            res_a  = '{out_kind: KIND_INCOMPLETE, out_byte: 8'd0,
                       out_value_len: 10'd0, out_last: 1'b1};
            push_n = 2'd1;
          end
          st_nxt      = st_idle;
          prev_cr_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '{phase: PH_REQ, pos: 4'd0, matching: 1'b1, cnt: 4'd0, vcnt: 10'd0};
      prev_cr_r <= 1'b0;
      wr_ptr_r  <= 2'd0;
      rd_ptr_r  <= 2'd0;
      q_cnt_r   <= 3'd0;
    end else begin
      st_r      <= st_nxt;
      prev_cr_r <= prev_cr_nxt;
      wr_ptr_r  <= wr_ptr_r + push_n;
      rd_ptr_r  <= rd_ptr_r + {1'b0, out_fire};
      q_cnt_r   <= q_cnt_r + {1'b0, push_n} - {2'b00, out_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_mem[wr_ptr_r] <= res_a;
    if (push_n == 2'd2) q_mem[wr_ptr_r + 2'd1] <= res_b;
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 3'(QDEPTH))
    else $error("result queue overflow");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && st_r.phase == PH_DONE) |-> push_n == 2'd0)
    else $error("result after status");

  a_pair_is_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == 2'd2) |-> (res_a.out_kind == KIND_BYTE && res_b.out_kind == KIND_BYTE))
    else $error("status pushed as part of a pair");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.in_last) |=> (st_r.phase == PH_REQ && !prev_cr_r))
    else $error("parser not back at request line after last byte");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_kind != KIND_BYTE) |-> out_data.out_last)
    else $error("status without out_last");
`endif

endmodule

`default_nettype wire
